### hdl/button_debounce_press_hold_unit_macros.svh
// Assertion macros shared by the button debounce RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef BUTTON_DEBOUNCE_PRESS_HOLD_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_HOLD_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BDPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BDPH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BDPH_ASSERT(lbl, prop, msg)
`define BDPH_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### hdl/bdph_pkg.sv
// Shared types and constants of the button debounce unit.
// No dependencies.
package bdph_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_DEBOUNCE = 2'd1;
  localparam logic [1:0] MODE_PRESSED  = 2'd2;
  localparam logic [1:0] MODE_HOLD     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_ENTRY_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_ENABLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_ENABLE     = 3'd4;

  localparam logic [TIME_W-1:0] DEBOUNCE_TIME_RST   = 32'd50;
  localparam logic [TIME_W-1:0] HOLD_TIME_RST       = 32'd1000;
  localparam logic [TIME_W-1:0] HOLD_ENTRY_TIME_RST = 32'd150;

  typedef struct packed {
    logic [TIME_W-1:0] debounce_time;
    logic [TIME_W-1:0] hold_time;
    logic [TIME_W-1:0] hold_entry_time;
    logic              press_enable;
    logic              hold_enable;
  } cfg_t;

  typedef struct packed {
    logic       press_event;
    logic       hold_event;
    logic       bounce_event;
    logic [1:0] mode_now;
  } result_t;

endpackage

### hdl/bdph_fsm.sv
// Next-state and event logic of the press/hold mode machine.
// Depends on bdph_pkg.
module bdph_fsm (
  input  bdph_pkg::cfg_t            cfg,
  input  logic [1:0]                mode,
  input  logic [bdph_pkg::TIME_W-1:0] mark_time,
  input  logic                      pin_pressed,
  input  logic [bdph_pkg::TIME_W-1:0] time_now,
  output logic                      mark_load,
  output bdph_pkg::result_t         res
);
  import bdph_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic              db_done;
  logic              entry_done;
  logic              hold_done;

  assign elapsed    = time_now - mark_time;
  assign db_done    = elapsed > cfg.debounce_time;
  assign entry_done = elapsed > cfg.hold_entry_time;
  assign hold_done  = elapsed > cfg.hold_time;

  always_comb begin
    res.press_event  = 1'b0;
    res.hold_event   = 1'b0;
    res.bounce_event = 1'b0;
    res.mode_now     = mode;
    mark_load        = 1'b0;
    case (mode)
      MODE_IDLE: begin
        if (pin_pressed) begin
          res.mode_now = MODE_DEBOUNCE;
          mark_load    = 1'b1;
        end
      end
      MODE_DEBOUNCE: begin
        if (db_done) begin
          if (pin_pressed) begin
            res.mode_now = MODE_PRESSED;
            mark_load    = 1'b1;
          end else begin
            res.mode_now     = MODE_IDLE;
            res.bounce_event = 1'b1;
          end
        end
      end
      MODE_PRESSED: begin
        if (!pin_pressed) begin
          res.press_event = cfg.press_enable;
          res.mode_now    = MODE_IDLE;
        end else if (entry_done) begin
          res.mode_now = MODE_HOLD;
          mark_load    = 1'b1;
        end
      end
      default: begin
        if (hold_done) begin
          res.hold_event = pin_pressed & cfg.hold_enable;
          res.mode_now   = MODE_IDLE;
        end
      end
    endcase
  end

endmodule

### hdl/button_debounce_press_hold_unit.sv
// Button debouncer with short-press and hold detection, top level.
// Input register, then result register; the mode machine and one subtract-compare sit
// between them. Throughput: one item per cycle unless out_stall holds a pending result.
// Reset (synchronous, active low) empties both stages, sets the mode to idle, clears
// the mark time and loads the configuration defaults. Depends on bdph_pkg and bdph_fsm.
`include "button_debounce_press_hold_unit_macros.svh"

module button_debounce_press_hold_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bdph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdph_pkg::TIME_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_pin_pressed,
  input  logic [bdph_pkg::TIME_W-1:0]    in_time_now,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_press_event,
  output logic                           out_hold_event,
  output logic                           out_bounce_event,
  output logic [1:0]                     out_mode_now
);
  import bdph_pkg::*;

  cfg_t              cfg_r;
  logic [1:0]        mode_r;
  logic [TIME_W-1:0] mark_time_r;
  logic              s1_valid_r;
  logic              s1_pin_r;
  logic [TIME_W-1:0] s1_time_r;
  logic              out_valid_r;
  result_t           res_r;
  result_t           res_nxt;
  logic              mark_load;
  logic              in_xfer;
  logic              adv;

  assign adv      = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= DEBOUNCE_TIME_RST;
      cfg_r.hold_time       <= HOLD_TIME_RST;
      cfg_r.hold_entry_time <= HOLD_ENTRY_TIME_RST;
      cfg_r.press_enable    <= 1'b0;
      cfg_r.hold_enable     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_TIME:   cfg_r.debounce_time   <= cfg_wdata;
        REG_HOLD_TIME:       cfg_r.hold_time       <= cfg_wdata;
        REG_HOLD_ENTRY_TIME: cfg_r.hold_entry_time <= cfg_wdata;
        REG_PRESS_ENABLE:    cfg_r.press_enable    <= cfg_wdata[0];
        REG_HOLD_ENABLE:     cfg_r.hold_enable     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pin_r  <= in_pin_pressed;
      s1_time_r <= in_time_now;
    end
  end

  bdph_fsm u_fsm (
    .cfg         (cfg_r),
    .mode        (mode_r),
    .mark_time   (mark_time_r),
    .pin_pressed (s1_pin_r),
    .time_now    (s1_time_r),
    .mark_load   (mark_load),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      mark_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        mode_r <= res_nxt.mode_now;
        if (mark_load) begin
          mark_time_r <= s1_time_r;
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_press_event  = res_r.press_event;
  assign out_hold_event   = res_r.hold_event;
  assign out_bounce_event = res_r.bounce_event;
  assign out_mode_now     = res_r.mode_now;

  `BDPH_ASSERT(a_events_exclusive, out_valid_r |-> $onehot0({res_r.press_event, res_r.hold_event, res_r.bounce_event}), "more than one event in a result")
  `BDPH_ASSERT(a_event_ends_idle, (out_valid_r && (res_r.press_event || res_r.hold_event || res_r.bounce_event)) |-> (res_r.mode_now == MODE_IDLE), "event reported without return to idle")
  `BDPH_ASSERT(a_mode_only_on_adv, !adv |=> $stable(mode_r), "mode changed without a stage advance")
  `BDPH_ASSERT(a_result_mode_match, ($past(adv && rst_n) && out_valid_r) |-> (res_r.mode_now == mode_r), "result mode differs from state")
  `BDPH_ASSERT_RST(a_reset_empties, !rst_n |=> (!s1_valid_r && !out_valid_r), "stages not empty after reset")

endmodule

### bench/tb.sv
// Self-checking testbench for button_debounce_press_hold_unit.
// Holds its own model of the debounce, press and hold machine, drives table-based and random
// pin samples with random idling on both channels. Depends on bdph_pkg and the unit's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdph_pkg::*;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_CHECKED, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic                   pin;
    logic [TIME_W-1:0]      val;
    result_t                want;
  } row_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int DIR_N = 33;
  localparam int PHASES = 10;

  row_t directed_rows [DIR_N] = '{
    '{ROW_CHECKED, 3'd0, 1'b0, 32'h0000_0000, '{1'b0, 1'b0, 1'b0, MODE_IDLE}},
    '{ROW_CHECKED, 3'd0, 1'b1, 32'hFFFF_FFF0, '{1'b0, 1'b0, 1'b0, MODE_DEBOUNCE}},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'h0000_0022, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'h0000_0023, '0},
    '{ROW_CHECKED, 3'd0, 1'b0, 32'h0000_0030, '{1'b0, 1'b0, 1'b0, MODE_IDLE}},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'hFFFF_FFFF, '0},
    '{ROW_CHECKED, 3'd0, 1'b0, 32'h0000_0033, '{1'b0, 1'b0, 1'b1, MODE_IDLE}},
    '{ROW_WRITE, REG_PRESS_ENABLE,    1'b0, 32'hFFFF_FFFF, '0},
    '{ROW_WRITE, REG_HOLD_ENABLE,     1'b0, 32'h0000_0001, '0},
    '{ROW_WRITE, REG_UNUSED_LO,       1'b0, 32'h0000_0000, '0},
    '{ROW_WRITE, REG_UNUSED_HI,       1'b0, 32'hFFFF_FFFF, '0},
    '{ROW_WRITE, REG_DEBOUNCE_TIME,   1'b0, 32'h0000_0000, '0},
    '{ROW_WRITE, REG_HOLD_ENTRY_TIME, 1'b0, 32'h0000_0002, '0},
    '{ROW_WRITE, REG_HOLD_TIME,       1'b0, 32'h0000_0003, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd1000, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd1000, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd1001, '0},
    '{ROW_CHECKED, 3'd0, 1'b0, 32'd1001, '{1'b1, 1'b0, 1'b0, MODE_IDLE}},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd2000, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd2001, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd2003, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd2004, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd2007, '0},
    '{ROW_CHECKED, 3'd0, 1'b1, 32'd2008, '{1'b0, 1'b1, 1'b0, MODE_IDLE}},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd3000, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd3001, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd3004, '0},
    '{ROW_SAMPLE,  3'd0, 1'b0, 32'd3005, '0},
    '{ROW_SAMPLE,  3'd0, 1'b0, 32'd3008, '0},
    '{ROW_WRITE, REG_PRESS_ENABLE,    1'b0, 32'hFFFF_FFFE, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd4000, '0},
    '{ROW_SAMPLE,  3'd0, 1'b1, 32'd4001, '0},
    '{ROW_CHECKED, 3'd0, 1'b0, 32'd4002, '{1'b0, 1'b0, 1'b0, MODE_IDLE}}
  };

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_pin_pressed = 1'b0;
  logic [TIME_W-1:0]    in_time_now = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_press_event;
  logic                 out_hold_event;
  logic                 out_bounce_event;
  logic [1:0]           out_mode_now;

  logic                 rst_s, in_stall_s, out_valid_s, out_stall_s;
  result_t              got_s;
  logic                 calm = 1'b0;
  int                   error_count = 0;

  cfg_t                 regs;
  logic [1:0]           btn_mode;
  logic [TIME_W-1:0]    mark_ms;
  result_t              awaited_events [$];

  button_debounce_press_hold_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pin_pressed   (in_pin_pressed),
    .in_time_now      (in_time_now),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_press_event  (out_press_event),
    .out_hold_event   (out_hold_event),
    .out_bounce_event (out_bounce_event),
    .out_mode_now     (out_mode_now)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Everything changes at the rising edge, so the falling edge sees settled values.
  always @(negedge clk) begin
    rst_s       = rst_n;
    in_stall_s  = in_stall;
    out_valid_s = out_valid;
    out_stall_s = out_stall;
    got_s       = {out_press_event, out_hold_event, out_bounce_event, out_mode_now};
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 34);
  end

  function automatic result_t advance_button(input logic pin, input logic [TIME_W-1:0] now);
    result_t           r;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    elapsed = now - mark_ms;
    case (btn_mode)
      MODE_IDLE: begin
        if (pin) begin
          btn_mode = MODE_DEBOUNCE;
          mark_ms = now;
        end
      end
      MODE_DEBOUNCE: begin
        if (elapsed > regs.debounce_time) begin
          if (pin) begin
            btn_mode = MODE_PRESSED;
            mark_ms = now;
          end else begin
            btn_mode = MODE_IDLE;
            r.bounce_event = 1'b1;
          end
        end
      end
      MODE_PRESSED: begin
        if (!pin) begin
          r.press_event = regs.press_enable;
          btn_mode = MODE_IDLE;
        end else if (elapsed > regs.hold_entry_time) begin
          btn_mode = MODE_HOLD;
          mark_ms = now;
        end
      end
      default: begin
        if (elapsed > regs.hold_time) begin
          r.hold_event = pin & regs.hold_enable;
          btn_mode = MODE_IDLE;
        end
      end
    endcase
    r.mode_now = btn_mode;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] tick(input int unsigned span, input logic wide);
    if (wide || $urandom_range(39) == 0) return $urandom;
    return $urandom_range(span, 0);
  endfunction

  task automatic send_sample(input logic pin, input logic [TIME_W-1:0] now,
                             input logic typed, input result_t typed_want);
    result_t predicted;
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pin_pressed <= pin;
    in_time_now    <= now;
    predicted = advance_button(pin, now);
    awaited_events.push_back(typed ? typed_want : predicted);
    @(posedge clk);
    while (in_stall_s) @(posedge clk);
  endtask

  // Lets every transfer in flight drain, then lets the two-stage pipeline go idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE_TIME:   regs.debounce_time = data;
      REG_HOLD_TIME:       regs.hold_time = data;
      REG_HOLD_ENTRY_TIME: regs.hold_entry_time = data;
      REG_PRESS_ENABLE:    regs.press_enable = data[0];
      REG_HOLD_ENABLE:     regs.hold_enable = data[0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_s && out_valid_s && !out_stall_s) begin
      if (awaited_events.size() == 0) begin
        $error("result transfer with no expected result waiting");
        error_count++;
      end else begin
        want = awaited_events.pop_front();
        if (got_s.press_event !== want.press_event) begin
          $error("press_event: expected %0d, got %0d", want.press_event, got_s.press_event);
          error_count++;
        end
        if (got_s.hold_event !== want.hold_event) begin
          $error("hold_event: expected %0d, got %0d", want.hold_event, got_s.hold_event);
          error_count++;
        end
        if (got_s.bounce_event !== want.bounce_event) begin
          $error("bounce_event: expected %0d, got %0d", want.bounce_event, got_s.bounce_event);
          error_count++;
        end
        if (got_s.mode_now !== want.mode_now) begin
          $error("mode_now: expected %0d, got %0d", want.mode_now, got_s.mode_now);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned       n_items, done, hold_len, rel_len, span;
    logic              wide;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] deb, entry, hold;
    regs     = '{DEBOUNCE_TIME_RST, HOLD_TIME_RST, HOLD_ENTRY_TIME_RST, 1'b0, 1'b0};
    btn_mode = MODE_IDLE;
    mark_ms  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_sample(directed_rows[i].pin, directed_rows[i].val,
                    directed_rows[i].kind == ROW_CHECKED, directed_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      deb   = $urandom_range(20, 0);
      entry = $urandom_range(30, 0);
      hold  = $urandom_range(60, 0);
      span  = 12;
      wide  = 1'b0;
      n_items = (p >= 1 && p <= 3) ? 30 : 115;
      case (p)
        0: begin
          deb = '0;
          entry = '0;
          hold = '0;
          span = 2;
        end
        1: deb = '1;
        2: entry = '1;
        3: hold = '1;
        4: begin
          deb = $urandom;
          entry = $urandom;
          hold = $urandom;
          wide = 1'b1;
        end
        default: ;
      endcase
      settle();
      write_reg(REG_DEBOUNCE_TIME, deb);
      write_reg(REG_HOLD_ENTRY_TIME, entry);
      write_reg(REG_HOLD_TIME, hold);
      write_reg(REG_PRESS_ENABLE, (p == 0) ? 32'h1 : $urandom);
      write_reg(REG_HOLD_ENABLE, (p == 0) ? 32'h1 : $urandom);
      calm <= (p == 5);
      now_ms = $urandom;
      done = 0;
      while (done < n_items) begin
        if ($urandom_range(99) < 80) begin
          hold_len = $urandom_range(20, 1);
          rel_len  = $urandom_range(6, 1);
          for (int k = 0; k < hold_len + rel_len && done < n_items; k++) begin
            now_ms = now_ms + tick(span, wide);
            send_sample(k < hold_len, now_ms, 1'b0, '0);
            done++;
          end
        end else begin
          now_ms = now_ms + tick(span, wide);
          send_sample(1'($urandom_range(1, 0)), now_ms, 1'b0, '0);
          done++;
        end
      end
    end
    calm <= 1'b0;

    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/bdph_pkg.sv
hdl/bdph_fsm.sv
hdl/button_debounce_press_hold_unit.sv
bench/tb.sv
